// ===== design/ebcpu_pkg.sv =====
// ----------------------------------------------------------------------------
// ebcpu_pkg
// shared types and constants for the eight-bit cpu subset core
// ----------------------------------------------------------------------------
package ebcpu_pkg;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [15:0] IO_PAGE = 16'hFF00;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] imm_lo;
    logic [7:0] imm_hi;
    logic [7:0] mem_lo;
    logic [7:0] mem_hi;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  access_kind;
    logic [15:0] bus_addr;
    logic [7:0]  bus_data;
    logic        last_access;
    logic [15:0] pc_after;
    logic [15:0] sp_after;
    logic [7:0]  acc_after;
    logic [3:0]  flags_after;
    logic        halted_flag;
  } out_req_t;

endpackage

// ===== design/eight_bit_cpu_subset_core_top.sv =====
// ----------------------------------------------------------------------------
// eight_bit_cpu_subset_core_top
// executes one instruction per input request, reports bus accesses
// ----------------------------------------------------------------------------
// channel | dir | payload   | handshake
// in_     | in  | in_req_t  | in_valid / in_stall
// out_    | out | out_req_t | out_valid / out_stall
//
// one instruction executes in the cycle it is accepted, its results land in
// a three-entry output buffer; one result request leaves per cycle while out_stall is low
// an instruction with two bus accesses pushes two result requests, others one
// input stalls only while buffer space for a worst-case instruction is lacking
// synchronous active-low reset clears all architectural state and the buffer
module eight_bit_cpu_subset_core_top import ebcpu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  // architectural state
  logic [7:0]  acc_r, b_r, c_r, d_r, e_r, h_r, l_r;
  logic [15:0] sp_r, pc_r;
  logic [3:0]  flg_r;
  logic        halt_r;

  // output fifo, three entries so one two-access instruction fits behind one
  out_req_t    q_r [3];
  logic [1:0]  rd_r, wr_r;
  logic [1:0]  cnt_r;

  logic [7:0]  acc_nxt, b_nxt, c_nxt, d_nxt, e_nxt, h_nxt, l_nxt;
  logic [15:0] sp_nxt, pc_nxt;
  logic [3:0]  flg_nxt;
  logic        halt_nxt;

  logic [1:0]  k0, k1;
  logic [15:0] a0, a1;
  logic [7:0]  dt0, dt1;
  logic        two;

  logic accept, pop;
  assign in_stall  = (cnt_r > 2'd1);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[rd_r];
  assign pop       = out_valid && !out_stall;

  function automatic logic [7:0] rget(input logic [2:0] r, input logic [7:0] a,
      input logic [7:0] b, input logic [7:0] c, input logic [7:0] d,
      input logic [7:0] e, input logic [7:0] h, input logic [7:0] l);
    logic [7:0] v;
    case (r)
      3'd0: v = b;
      3'd1: v = c;
      3'd2: v = d;
      3'd3: v = e;
      3'd4: v = h;
      3'd5: v = l;
      3'd7: v = a;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // instruction decode and execute
  always_comb begin
    logic [7:0]  op, il, ih, ml, mh, v, src_v;
    logic [2:0]  r;
    logic [15:0] hl, bc, de, imm16, pc1, pr, ret;
    logic [8:0]  s;
    logic [1:0]  pi;
    op = in_data.opcode; il = in_data.imm_lo; ih = in_data.imm_hi;
    ml = in_data.mem_lo; mh = in_data.mem_hi;
    r = op[5:3];
    hl = {h_r, l_r}; bc = {b_r, c_r}; de = {d_r, e_r};
    imm16 = {ih, il};
    pc1 = pc_r + 16'd1;
    src_v = rget(op[2:0], acc_r, b_r, c_r, d_r, e_r, h_r, l_r);
    v = 8'h00; s = 9'd0; pr = 16'h0; ret = 16'h0; pi = 2'd0;
    acc_nxt = acc_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r;
    h_nxt = h_r; l_nxt = l_r; sp_nxt = sp_r; pc_nxt = pc1; flg_nxt = flg_r;
    halt_nxt = halt_r;
    k0 = KIND_NONE; a0 = 16'h0; dt0 = 8'h0;
    k1 = KIND_NONE; a1 = 16'h0; dt1 = 8'h0; two = 1'b0;
    if (halt_r) begin
      pc_nxt = pc_r;
    end else if (op == 8'h00 || op == 8'h76) begin
      halt_nxt = 1'b1;
    end else if (op[7:6] == 2'b01) begin
      // 8-bit register and (hl) moves
      if (op[2:0] == 3'd6) begin
        k0 = KIND_READ; a0 = hl; dt0 = ml; v = ml;
      end else begin
        v = src_v;
        if (r == 3'd6) begin
          k0 = KIND_WRITE; a0 = hl; dt0 = src_v;
        end
      end
      if (r != 3'd6) begin
        case (r)
          3'd0: b_nxt = v;
          3'd1: c_nxt = v;
          3'd2: d_nxt = v;
          3'd3: e_nxt = v;
          3'd4: h_nxt = v;
          3'd5: l_nxt = v;
          default: acc_nxt = v;
        endcase
      end
    end else if (op[7:6] == 2'b00 && (op[2:0] == 3'd4 || op[2:0] == 3'd5)) begin
      // 8-bit increment and decrement
      v = (r == 3'd6) ? ml : rget(r, acc_r, b_r, c_r, d_r, e_r, h_r, l_r);
      v = op[0] ? v - 8'd1 : v + 8'd1;
      flg_nxt[3] = (v == 8'h00);
      flg_nxt[2] = op[0];
      if (r == 3'd6) begin
        k0 = KIND_READ; a0 = hl; dt0 = ml;
        k1 = KIND_WRITE; a1 = hl; dt1 = v; two = 1'b1;
      end else begin
        case (r)
          3'd0: b_nxt = v;
          3'd1: c_nxt = v;
          3'd2: d_nxt = v;
          3'd3: e_nxt = v;
          3'd4: h_nxt = v;
          3'd5: l_nxt = v;
          default: acc_nxt = v;
        endcase
      end
    end else if (op[7:6] == 2'b00 && op[2:0] == 3'd6) begin
      pc_nxt = pc_r + 16'd2;
      case (r)
        3'd0: b_nxt = il;
        3'd1: c_nxt = il;
        3'd2: d_nxt = il;
        3'd3: e_nxt = il;
        3'd4: h_nxt = il;
        3'd5: l_nxt = il;
        3'd6: begin k0 = KIND_WRITE; a0 = hl; dt0 = il; end
        default: acc_nxt = il;
      endcase
    end else if (op[7:6] == 2'b00 && (op[3:0] == 4'h1 || op[3:0] == 4'h3
                 || op[3:0] == 4'hB)) begin
      // 16-bit load, increment, decrement
      pi = op[5:4];
      if (op[3:0] == 4'h1) pc_nxt = pc_r + 16'd3;
      case (pi)
        2'd0: pr = bc;
        2'd1: pr = de;
        2'd2: pr = hl;
        default: pr = sp_r;
      endcase
      case (op[3:0])
        4'h1: pr = imm16;
        4'h3: pr = pr + 16'd1;
        default: pr = pr - 16'd1;
      endcase
      case (pi)
        2'd0: {b_nxt, c_nxt} = pr;
        2'd1: {d_nxt, e_nxt} = pr;
        2'd2: {h_nxt, l_nxt} = pr;
        default: sp_nxt = pr;
      endcase
    end else if (op[7:3] == 5'b10101 || op == 8'hEE) begin
      // xor clears n, h and c
      if (op == 8'hEE) begin
        v = il; pc_nxt = pc_r + 16'd2;
      end else if (op[2:0] == 3'd6) begin
        v = ml; k0 = KIND_READ; a0 = hl; dt0 = ml;
      end else begin
        v = src_v;
      end
      acc_nxt = acc_r ^ v;
      flg_nxt = {(acc_nxt == 8'h00), 3'b000};
    end else begin
      case (op)
        8'h02: begin k0 = KIND_WRITE; a0 = bc; dt0 = acc_r; end
        8'h12: begin k0 = KIND_WRITE; a0 = de; dt0 = acc_r; end
        8'h22: begin
          k0 = KIND_WRITE; a0 = hl; dt0 = acc_r; {h_nxt, l_nxt} = hl + 16'd1;
        end
        8'h32: begin
          k0 = KIND_WRITE; a0 = hl; dt0 = acc_r; {h_nxt, l_nxt} = hl - 16'd1;
        end
        8'h0A: begin k0 = KIND_READ; a0 = bc; dt0 = ml; acc_nxt = ml; end
        8'h1A: begin k0 = KIND_READ; a0 = de; dt0 = ml; acc_nxt = ml; end
        8'h2A: begin
          k0 = KIND_READ; a0 = hl; dt0 = ml; acc_nxt = ml;
          {h_nxt, l_nxt} = hl + 16'd1;
        end
        8'h3A: begin
          k0 = KIND_READ; a0 = hl; dt0 = ml; acc_nxt = ml;
          {h_nxt, l_nxt} = hl - 16'd1;
        end
        8'h17: begin
          flg_nxt[0] = acc_r[7];
          acc_nxt = {acc_r[6:0], flg_r[0]};
        end
        8'h18, 8'h20, 8'h28: begin
          pc_nxt = pc_r + 16'd2;
          if (op == 8'h18 || (op == 8'h20 && !flg_r[3]) || (op == 8'h28 && flg_r[3]))
            pc_nxt = pc_r + 16'd2 + {{8{il[7]}}, il};
        end
        8'h86: begin
          k0 = KIND_READ; a0 = hl; dt0 = ml;
          s = {1'b0, acc_r} + {1'b0, ml};
          acc_nxt = s[7:0];
          flg_nxt = {(s[7:0] == 8'h00), 1'b0, flg_r[1], s[8]};
        end
        8'h90: begin
          acc_nxt = acc_r - b_r;
          flg_nxt = {(acc_r == b_r), 1'b1, flg_r[1], (acc_r < b_r)};
        end
        8'hBE: begin
          k0 = KIND_READ; a0 = hl; dt0 = ml;
          flg_nxt = {(acc_r == ml), 1'b1, flg_r[1], (acc_r < ml)};
        end
        8'hFE: begin
          pc_nxt = pc_r + 16'd2;
          flg_nxt = {(acc_r == il), 1'b1, flg_r[1], (acc_r < il)};
        end
        8'hC1, 8'hC9: begin
          k0 = KIND_READ; a0 = sp_r; dt0 = ml;
          k1 = KIND_READ; a1 = sp_r + 16'd1; dt1 = mh; two = 1'b1;
          sp_nxt = sp_r + 16'd2;
          if (op == 8'hC1) begin
            c_nxt = ml; b_nxt = mh;
          end else begin
            pc_nxt = {mh, ml};
          end
        end
        8'hC5: begin
          k0 = KIND_WRITE; a0 = sp_r - 16'd1; dt0 = b_r;
          k1 = KIND_WRITE; a1 = sp_r - 16'd2; dt1 = c_r; two = 1'b1;
          sp_nxt = sp_r - 16'd2;
        end
        8'hCD: begin
          ret = pc_r + 16'd3;
          k0 = KIND_WRITE; a0 = sp_r - 16'd1; dt0 = ret[15:8];
          k1 = KIND_WRITE; a1 = sp_r - 16'd2; dt1 = ret[7:0]; two = 1'b1;
          sp_nxt = sp_r - 16'd2;
          pc_nxt = imm16;
        end
        8'hE0: begin
          pc_nxt = pc_r + 16'd2; k0 = KIND_WRITE; a0 = IO_PAGE + {8'h00, il};
          dt0 = acc_r;
        end
        8'hF0: begin
          pc_nxt = pc_r + 16'd2; k0 = KIND_READ; a0 = IO_PAGE + {8'h00, il};
          dt0 = ml; acc_nxt = ml;
        end
        8'hE2: begin k0 = KIND_WRITE; a0 = IO_PAGE + {8'h00, c_r}; dt0 = acc_r; end
        8'hF2: begin
          k0 = KIND_READ; a0 = IO_PAGE + {8'h00, c_r}; dt0 = ml; acc_nxt = ml;
        end
        8'hEA: begin pc_nxt = pc_r + 16'd3; k0 = KIND_WRITE; a0 = imm16; dt0 = acc_r; end
        default: ;
      endcase
    end
  end

  // result requests for this instruction
  out_req_t res0, res1;
  always_comb begin
    res0 = '{access_kind: k0, bus_addr: a0, bus_data: dt0, last_access: !two,
             pc_after: pc_nxt, sp_after: sp_nxt, acc_after: acc_nxt,
             flags_after: flg_nxt, halted_flag: halt_nxt};
    res1 = res0;
    res1.access_kind = k1; res1.bus_addr = a1; res1.bus_data = dt1;
    res1.last_access = 1'b1;
  end

  function automatic logic [1:0] inc3(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  // fifo payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_r] <= res0;
      if (two) q_r[inc3(wr_r)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0; e_r <= '0; h_r <= '0;
      l_r <= '0; sp_r <= '0; pc_r <= '0; flg_r <= '0; halt_r <= 1'b0;
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      if (accept) begin
        acc_r <= acc_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt;
        e_r <= e_nxt; h_r <= h_nxt; l_r <= l_nxt; sp_r <= sp_nxt;
        pc_r <= pc_nxt; flg_r <= flg_nxt; halt_r <= halt_nxt;
        wr_r <= two ? inc3(inc3(wr_r)) : inc3(wr_r);
      end
      if (pop) rd_r <= inc3(rd_r);
      cnt_r <= cnt_r + (accept ? (two ? 2'd2 : 2'd1) : 2'd0) - (pop ? 2'd1 : 2'd0);
    end
  end

endmodule
